/* rtl/fhv_pkg.sv */
// Shared types and constants for the floating-horizon visibility block.
package fhv_pkg;

    typedef logic signed [15:0] coord_t;
    typedef logic [1:0]         pen_t;
    typedef logic [10:0]        height_t;

    // Item operations
    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_POINT = 1'b1;

    // Pen codes
    localparam pen_t PEN_DEFAULT = 2'd0;
    localparam pen_t PEN_BLUE    = 2'd1;
    localparam pen_t PEN_WHITE   = 2'd2;

    // Initial upper horizon: -1 pixel in Q12.4
    localparam logic signed [17:0] INIT_UPPER = -18'sd16;
    localparam int                 FRAC_BITS  = 4;

    // Register map: register index is the word address bit
    localparam int      PADDR_W             = 3;
    localparam logic    REG_SCREEN_HEIGHT   = 1'b0;
    localparam height_t SCREEN_HEIGHT_RESET = 11'd480;

endpackage

/* rtl/fhv_if.sv */
// Point and draw channel interfaces.
interface fhv_pt_if;
    import fhv_pkg::*;
    logic   valid;
    logic   ready;
    logic   op;
    logic [7:0] column;
    coord_t pos_x;
    coord_t pos_y;
    logic   first_section;

    modport source (output valid, op, column, pos_x, pos_y, first_section, input ready);
    modport sink   (input valid, op, column, pos_x, pos_y, first_section, output ready);
endinterface

interface fhv_draw_if;
    import fhv_pkg::*;
    logic   valid;
    logic   ready;
    coord_t draw_x;
    coord_t draw_y;
    pen_t   pen_color;
    logic   last;

    modport source (output valid, draw_x, draw_y, pen_color, last, input ready);
    modport sink   (input valid, draw_x, draw_y, pen_color, last, output ready);
endinterface

/* rtl/fhv_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fhv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/floating_horizon_visibility.sv */
// Floating-horizon hidden-line visibility test, top level.
//
// Channels: pts takes items (clear or point), draws gives draw transfers,
// both valid/ready. screen_height sits at APB address 0, pready always high.
// A clear item resets every column to its initial horizons and the pen to
// the default; it gives no draw. A point gives zero, one or two draws, the
// lower-horizon draw first; last marks the final draw of the point.
// A point's first draw passes the horizon RAM read and compare-stage load,
// made as the point is taken, then the result register, which presents it.
// Throughput: one item per cycle while each point gives at most one draw
// and draws does not stall; a point with two draws holds the compare stage
// for its second draw.
// The horizon RAM's read-after-write gap is covered by a one-entry bypass.
// Reset clears the column-touched flags, the pen and all valid flags at
// once; the horizon RAM is not cleared. When draws stalls, the result register
// holds, and the compare stage and input stop once a point with a draw waits.
module floating_horizon_visibility #(
    parameter int COLUMNS = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    fhv_pt_if.sink                      pts,
    fhv_draw_if.source                  draws,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fhv_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import fhv_pkg::*;

    localparam int AW = $clog2(COLUMNS);

    // Configuration
    height_t height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= SCREEN_HEIGHT_RESET;
        end
        else if (psel && penable && pwrite && paddr[PADDR_W-1] == REG_SCREEN_HEIGHT)
        begin
            height_reg <= pwdata[10:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_SCREEN_HEIGHT) ? 32'(height_reg) : 32'd0;

    // Compare stage registers
    logic          s1_valid_reg;
    logic          s1_op_reg;
    logic          s1_ok_reg;
    logic [AW-1:0] s1_addr_reg;
    coord_t        s1_x_reg;
    coord_t        s1_y_reg;
    logic          s1_first_reg;
    logic          s1_phase_reg;

    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [31:0]   fwd_data_reg;

    logic [COLUMNS-1:0] touched_reg;
    pen_t               pen_reg;

    logic   out_valid_reg;
    coord_t out_x_reg;
    coord_t out_y_reg;
    pen_t   out_pen_reg;
    logic   out_last_reg;

    logic        pt_acc;
    logic        col_ok;
    logic [31:0] ram_rdata;
    logic [31:0] hor;
    coord_t      hor_up;
    coord_t      hor_low;
    logic        touched;
    logic [11:0] height_p1;
    logic signed [17:0] init_low;
    logic signed [17:0] cur_up;
    logic signed [17:0] cur_low;
    logic signed [17:0] y_ext;
    logic        lo_pass;
    logic        up_pass;
    logic        is_pt;
    logic        any_draw;
    logic        two_draws;
    logic        out_free;
    logic        emit_go;
    logic        emit_last;
    logic        emit_low;
    logic        s1_done;
    logic        ram_we;
    coord_t      new_up;
    coord_t      new_low;
    pen_t        draw_pen;

    assign pt_acc = pts.valid && pts.ready;
    assign col_ok = 32'(pts.column) < 32'(COLUMNS);

    fhv_ram #(
        .WIDTH (32),
        .DEPTH (COLUMNS)
    ) u_hor_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata ({new_up, new_low}),
        .re    (pt_acc),
        .raddr (AW'(pts.column)),
        .rdata (ram_rdata)
    );

    // Bypass the write made at the same edge as this item's read
    assign hor     = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg : ram_rdata;
    assign hor_up  = hor[31:16];
    assign hor_low = hor[15:0];
    assign touched = touched_reg[s1_addr_reg];

    assign height_p1 = {1'b0, height_reg} + 12'd1;
    assign init_low  = {2'b00, height_p1, FRAC_BITS'(0)};
    assign cur_up    = touched ? 18'(hor_up) : INIT_UPPER;
    assign cur_low   = touched ? 18'(hor_low) : init_low;
    assign y_ext     = 18'(s1_y_reg);

    assign lo_pass = y_ext < cur_low;
    assign up_pass = y_ext > cur_up;
    assign new_low = lo_pass ? s1_y_reg : cur_low[15:0];
    assign new_up  = up_pass ? s1_y_reg : cur_up[15:0];

    assign is_pt     = s1_op_reg == OP_POINT && s1_ok_reg;
    assign any_draw  = is_pt && (lo_pass || up_pass);
    assign two_draws = is_pt && lo_pass && up_pass;
    assign out_free  = !out_valid_reg || draws.ready;
    assign emit_go   = s1_valid_reg && any_draw && out_free;
    assign emit_last = !two_draws || s1_phase_reg;
    assign emit_low  = !s1_phase_reg && lo_pass;
    assign s1_done   = s1_valid_reg && (!any_draw || (out_free && emit_last));
    assign ram_we    = s1_done && is_pt;

    assign draw_pen = s1_first_reg ? pen_reg : (emit_low ? PEN_BLUE : PEN_WHITE);

    assign pts.ready = !s1_valid_reg || s1_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_phase_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            touched_reg   <= '0;
            pen_reg       <= PEN_DEFAULT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pt_acc)
            begin
                s1_valid_reg  <= 1'b1;
                fwd_valid_reg <= ram_we;
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_done)
            begin
                s1_phase_reg <= 1'b0;
            end
            else if (emit_go)
            begin
                s1_phase_reg <= 1'b1;
            end

            if (s1_done)
            begin
                if (s1_op_reg == OP_CLEAR)
                begin
                    touched_reg <= '0;
                    pen_reg     <= PEN_DEFAULT;
                end
                else if (is_pt)
                begin
                    touched_reg[s1_addr_reg] <= 1'b1;
                    if (!s1_first_reg)
                    begin
                        if (up_pass)
                        begin
                            pen_reg <= PEN_WHITE;
                        end
                        else if (lo_pass)
                        begin
                            pen_reg <= PEN_BLUE;
                        end
                    end
                end
            end

            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (draws.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pt_acc)
        begin
            s1_op_reg    <= pts.op;
            s1_ok_reg    <= col_ok;
            s1_addr_reg  <= AW'(pts.column);
            s1_x_reg     <= pts.pos_x;
            s1_y_reg     <= pts.pos_y;
            s1_first_reg <= pts.first_section;
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= {new_up, new_low};
        end
        if (emit_go)
        begin
            out_x_reg    <= s1_x_reg;
            out_y_reg    <= s1_y_reg;
            out_pen_reg  <= draw_pen;
            out_last_reg <= emit_last;
        end
    end

    assign draws.valid     = out_valid_reg;
    assign draws.draw_x    = out_x_reg;
    assign draws.draw_y    = out_y_reg;
    assign draws.pen_color = out_pen_reg;
    assign draws.last      = out_last_reg;

    // The second draw of a point follows its first with no gap
    a_second_draw_follows: assert property (@(posedge clk) disable iff (!rst_n)
        draws.valid && draws.ready && !draws.last |=> draws.valid)
        else $error("second draw of a point did not follow");

    // Only a point with two draws may sit in its second phase
    a_phase_two_draws: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_phase_reg |-> is_pt && lo_pass && up_pass)
        else $error("compare stage in second phase without two draws");

    // An empty compare stage always takes input
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> pts.ready)
        else $error("input stalled with empty compare stage");

    a_pen_code: assert property (@(posedge clk) disable iff (!rst_n)
        draws.valid |-> (draws.pen_color == PEN_DEFAULT) || (draws.pen_color == PEN_BLUE)
                        || (draws.pen_color == PEN_WHITE))
        else $error("draw with undefined pen code");
endmodule
